FILE: hw/rtl/crc8frc_pkg.sv
// crc8frc_pkg: shared codes, constants and structs of the crc8 frame receive checker
// no dependencies
`timescale 1ns / 1ps

package crc8frc_pkg;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_CRC  = 2'd1;
  localparam logic [1:0] STAT_SIZE = 2'd2;
  localparam logic [1:0] STAT_TERM = 2'd3;

  localparam logic [7:0] NEWLINE  = 8'h0A;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef struct packed {
    logic       start;
    logic [7:0] seed;
    logic [7:0] data;
  } crc_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] crc;
  } crc_rsp_t;

endpackage

FILE: hw/rtl/crc8frc_crc.sv
// crc8frc_crc: bit-serial crc-8 unit, one bit per cycle
// depends on crc8frc_pkg
`timescale 1ns / 1ps

module crc8frc_crc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crc8frc_pkg::crc_req_t req_i,
  output crc8frc_pkg::crc_rsp_t rsp_o
);

  logic [7:0] crc_q, crc_d;
  logic [7:0] sh_q, sh_d;
  logic [2:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic       fb;

  always_comb begin
    crc_d  = crc_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    fb     = crc_q[0] ^ sh_q[0];
    if (req_i.start) begin
      crc_d  = req_i.seed;
      sh_d   = req_i.data;
      cnt_d  = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = {1'b0, crc_q[7:1]} ^ (fb ? crc8frc_pkg::CRC_POLY : 8'h00);
      sh_d  = {1'b0, sh_q[7:1]};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= crc8frc_pkg::CRC_INIT;
      sh_q   <= 8'h00;
      cnt_q  <= 3'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      sh_q   <= sh_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.crc  = crc_q;

endmodule

FILE: hw/rtl/crc8frc_buf.sv
// crc8frc_buf: payload buffer, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module crc8frc_buf #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                              clk_i,
  input  logic                                              wr_en_i,
  input  logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr_i,
  input  logic [7:0]                                        wr_data_i,
  input  logic                                              rd_en_i,
  input  logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr_i,
  output logic [7:0]                                        rd_data_o
);

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/crc8_frame_receive_checker.sv
// crc8_frame_receive_checker: frame parser with crc-8 check and payload release
// depends on crc8frc_pkg, crc8frc_crc, crc8frc_buf
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_stall_o | rx_byte_i
//   output  | out       | out_valid_o / out_stall_i | kind_o data_o status_o send_ack_o last_o
//
// crc and discarded bytes are taken without stalling the input; a byte that ends in a status
// stalls the input until the status transaction is loaded; size and payload bytes stall it
// while the bit-serial crc unit loads, runs its eight shift steps and signals done
// a good terminator releases the buffer one payload byte at a time (a memory read, then an
// output load that waits for a free output register), then the status transaction
// reset is asynchronous active low and clears all control state, the buffer is not cleared
// out_stall_i holds the output register; input is stalled while a byte is being processed
`timescale 1ns / 1ps

module crc8_frame_receive_checker #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] data_o,
  output logic [1:0] status_o,
  output logic       send_ack_o,
  output logic       last_o
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [2:0] PH_CRC  = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_TERM = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] rcrc_q, rcrc_d;
  logic [6:0] fsize_q, fsize_d;
  logic [5:0] cnt_q, cnt_d;
  logic [7:0] run_crc_q, run_crc_d;
  logic [5:0] rd_idx_q, rd_idx_d;
  logic [1:0] stat_q, stat_d;

  logic       ovalid_q, ovalid_d;
  logic       okind_q, okind_d;
  logic [7:0] odata_q, odata_d;
  logic [1:0] ostat_q, ostat_d;
  logic       oack_q, oack_d;
  logic       olast_q, olast_d;

  crc8frc_pkg::crc_req_t crc_req;
  crc8frc_pkg::crc_rsp_t crc_rsp;

  logic       accept;
  logic       out_free;
  logic       wr_en;
  logic       rd_en;
  logic [7:0] rd_data;
  logic [5:0] cnt_inc;
  logic [5:0] rd_inc;
  logic       size_bad;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign cnt_inc    = cnt_q + 6'd1;
  assign rd_inc     = rd_idx_q + 6'd1;
  assign size_bad   = (rx_byte_i == 8'd0) ||
                      ({1'b0, rx_byte_i} > 9'(MAX_PAYLOAD + 1));

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    rcrc_d    = rcrc_q;
    fsize_d   = fsize_q;
    cnt_d     = cnt_q;
    run_crc_d = run_crc_q;
    rd_idx_d  = rd_idx_q;
    stat_d    = stat_q;
    ovalid_d  = ovalid_q && out_stall_i;
    okind_d   = okind_q;
    odata_d   = odata_q;
    ostat_d   = ostat_q;
    oack_d    = oack_q;
    olast_d   = olast_q;
    crc_req.start = 1'b0;
    crc_req.seed  = crc8frc_pkg::CRC_INIT;
    crc_req.data  = rx_byte_i;
    wr_en = 1'b0;
    rd_en = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (phase_q)
            PH_SIZE: begin
              if (size_bad) begin
                stat_d  = crc8frc_pkg::STAT_SIZE;
                state_d = S_STAT;
                phase_d = (rx_byte_i == crc8frc_pkg::NEWLINE) ? PH_CRC : PH_SKIP;
              end else begin
                fsize_d       = rx_byte_i[6:0];
                cnt_d         = 6'd0;
                crc_req.start = 1'b1;
                crc_req.seed  = crc8frc_pkg::CRC_INIT;
                state_d       = S_CRC;
                phase_d       = (rx_byte_i == 8'd1) ? PH_TERM : PH_BODY;
              end
            end
            PH_BODY: begin
              wr_en         = (cnt_q < 6'(MAX_PAYLOAD));
              crc_req.start = 1'b1;
              crc_req.seed  = run_crc_q;
              cnt_d         = cnt_inc;
              state_d       = S_CRC;
              if (({1'b0, cnt_inc} + 7'd1) >= fsize_q) begin
                phase_d = PH_TERM;
              end
            end
            PH_TERM: begin
              phase_d = PH_CRC;
              if (rx_byte_i != crc8frc_pkg::NEWLINE) begin
                stat_d  = crc8frc_pkg::STAT_TERM;
                state_d = S_STAT;
                phase_d = PH_SKIP;
              end else if (run_crc_q == rcrc_q) begin
                stat_d   = crc8frc_pkg::STAT_OK;
                rd_idx_d = 6'd0;
                state_d  = (cnt_q == 6'd0) ? S_STAT : S_RD;
              end else begin
                stat_d  = crc8frc_pkg::STAT_CRC;
                state_d = S_STAT;
              end
            end
            PH_SKIP: begin
              if (rx_byte_i == crc8frc_pkg::NEWLINE) begin
                phase_d = PH_CRC;
              end
            end
            default: begin
              rcrc_d    = rx_byte_i;
              run_crc_d = crc8frc_pkg::CRC_INIT;
              cnt_d     = 6'd0;
              phase_d   = PH_SIZE;
            end
          endcase
        end
      end
      S_CRC: begin
        if (crc_rsp.done) begin
          run_crc_d = crc_rsp.crc;
          state_d   = S_IDLE;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = crc8frc_pkg::KIND_DATA;
          odata_d  = rd_data;
          ostat_d  = crc8frc_pkg::STAT_OK;
          oack_d   = 1'b0;
          olast_d  = 1'b0;
          rd_idx_d = rd_inc;
          state_d  = (rd_inc == cnt_q) ? S_STAT : S_RD;
        end
      end
      S_STAT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = crc8frc_pkg::KIND_STAT;
          odata_d  = 8'h00;
          ostat_d  = stat_q;
          oack_d   = (stat_q == crc8frc_pkg::STAT_OK);
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_CRC;
      rcrc_q    <= 8'h00;
      fsize_q   <= 7'd0;
      cnt_q     <= 6'd0;
      run_crc_q <= crc8frc_pkg::CRC_INIT;
      rd_idx_q  <= 6'd0;
      stat_q    <= crc8frc_pkg::STAT_OK;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      rcrc_q    <= rcrc_d;
      fsize_q   <= fsize_d;
      cnt_q     <= cnt_d;
      run_crc_q <= run_crc_d;
      rd_idx_q  <= rd_idx_d;
      stat_q    <= stat_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    odata_q <= odata_d;
    ostat_q <= ostat_d;
    oack_q  <= oack_d;
    olast_q <= olast_d;
  end

  crc8frc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .rsp_o  (crc_rsp)
  );

  crc8frc_buf #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = ovalid_q;
  assign kind_o      = okind_q;
  assign data_o      = odata_q;
  assign status_o    = ostat_q;
  assign send_ack_o  = oack_q;
  assign last_o      = olast_q;

endmodule

FILE: hw/rtl/crc8frc_checker.sv
// crc8frc_checker: port-level assertions for the crc8 frame receive checker
// depends on crc8frc_pkg; bound to crc8_frame_receive_checker
`timescale 1ns / 1ps

module crc8frc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       kind_o,
  input logic [7:0] data_o,
  input logic [1:0] status_o,
  input logic       send_ack_o,
  input logic       last_o
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(data_o)
      && $stable(status_o) && $stable(send_ack_o) && $stable(last_o))
    else $error("stalled output transaction changed");

  // payload bytes are only shown while the input side is held off
  a_data_stalls_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == crc8frc_pkg::KIND_DATA) |-> in_stall_o)
    else $error("input accepted while payload release in progress");

  // payload byte fields
  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == crc8frc_pkg::KIND_DATA) |->
      !last_o && !send_ack_o && (status_o == crc8frc_pkg::STAT_OK))
    else $error("bad payload byte fields");

  // ack only on ok status, status always ends the run
  a_stat_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == crc8frc_pkg::KIND_STAT) |->
      last_o && (data_o == 8'h00)
      && (send_ack_o == (status_o == crc8frc_pkg::STAT_OK)))
    else $error("bad status fields");

endmodule

bind crc8_frame_receive_checker crc8frc_checker u_crc8frc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .rx_byte_i   (rx_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .data_o      (data_o),
  .status_o    (status_o),
  .send_ack_o  (send_ack_o),
  .last_o      (last_o)
);

FILE: test/crc8_frame_receive_checker_test.sv
// crc8_frame_receive_checker_test: self-checking bench for the crc-8 frame receive checker
// drives framed and broken byte streams, predicts released payload and status transactions
// depends on crc8frc_pkg and crc8_frame_receive_checker
`timescale 1ns / 1ps

module crc8_frame_receive_checker_test;

  localparam int MAX_PAYLOAD = 32;
  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 200;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [2:0] {
    AWAIT_CRC,
    AWAIT_SIZE,
    IN_BODY,
    AWAIT_TERM,
    DROPPING
  } rx_phase_e;

  typedef enum int {
    NO_STALL,
    SPARSE_STALL,
    PERIODIC_STALL,
    HEAVY_STALL
  } stall_style_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       ack;
    logic       last;
  } frame_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       kind_o;
  logic [7:0] data_o;
  logic [1:0] status_o;
  logic       send_ack_o;
  logic       last_o;

  crc8_frame_receive_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .data_o     (data_o),
    .status_o   (status_o),
    .send_ack_o (send_ack_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame parser prediction state
  rx_phase_e  rx_phase = AWAIT_CRC;
  logic [7:0] sent_crc = 8'h00;
  logic [6:0] size_byte = 7'd0;
  logic [5:0] body_count = 6'd0;
  logic [7:0] crc_acc = 8'h00;
  logic [7:0] body_buf[MAX_PAYLOAD];

  frame_out_t frame_out_q[$];
  int         mismatch_count = 0;
  int         sent_items = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ crc8frc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic void push_status(input logic [1:0] st);
    frame_out_t r;
    r.kind   = crc8frc_pkg::KIND_STAT;
    r.data   = 8'h00;
    r.status = st;
    r.ack    = (st == crc8frc_pkg::STAT_OK);
    r.last   = 1'b1;
    frame_out_q.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_out_t r;
    case (rx_phase)
      AWAIT_SIZE: begin
        if (b == 8'h00 || int'(b) > MAX_PAYLOAD + 1) begin
          push_status(crc8frc_pkg::STAT_SIZE);
          rx_phase = (b == crc8frc_pkg::NEWLINE) ? AWAIT_CRC : DROPPING;
        end else begin
          size_byte  = b[6:0];
          crc_acc    = crc8_update(crc8frc_pkg::CRC_INIT, b);
          body_count = 6'd0;
          rx_phase   = (b == 8'h01) ? AWAIT_TERM : IN_BODY;
        end
      end
      IN_BODY: begin
        if (int'(body_count) < MAX_PAYLOAD) body_buf[body_count[AW-1:0]] = b;
        crc_acc    = crc8_update(crc_acc, b);
        body_count = body_count + 6'd1;
        if (int'(body_count) + 1 >= int'(size_byte)) rx_phase = AWAIT_TERM;
      end
      AWAIT_TERM: begin
        if (b != crc8frc_pkg::NEWLINE) begin
          push_status(crc8frc_pkg::STAT_TERM);
          rx_phase = DROPPING;
        end else if (crc_acc == sent_crc) begin
          for (int i = 0; i < int'(body_count) && i < MAX_PAYLOAD; i++) begin
            r.kind   = crc8frc_pkg::KIND_DATA;
            r.data   = body_buf[AW'(i)];
            r.status = crc8frc_pkg::STAT_OK;
            r.ack    = 1'b0;
            r.last   = 1'b0;
            frame_out_q.push_back(r);
          end
          push_status(crc8frc_pkg::STAT_OK);
          rx_phase = AWAIT_CRC;
        end else begin
          push_status(crc8frc_pkg::STAT_CRC);
          rx_phase = AWAIT_CRC;
        end
      end
      DROPPING: begin
        if (b == crc8frc_pkg::NEWLINE) rx_phase = AWAIT_CRC;
      end
      default: begin
        sent_crc   = b;
        crc_acc    = crc8frc_pkg::CRC_INIT;
        body_count = 6'd0;
        rx_phase   = AWAIT_SIZE;
      end
    endcase
  endfunction

  // one input transaction, with bursts and random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_items++;
    parse_rx_byte(b);
  endtask

  task automatic send_frame(input byte_q_t pay, input bit crc_good, input logic [7:0] term);
    logic [7:0] sz;
    logic [7:0] crc;
    sz  = 8'(pay.size() + 1);
    crc = crc8_update(crc8frc_pkg::CRC_INIT, sz);
    foreach (pay[i]) crc = crc8_update(crc, pay[i]);
    if (!crc_good) crc ^= 8'(1 << $urandom_range(0, 7));
    send_byte(crc);
    send_byte(sz);
    foreach (pay[i]) send_byte(pay[i]);
    send_byte(term);
  endtask

  task automatic send_junk_line(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == crc8frc_pkg::NEWLINE) b = 8'h00;
      send_byte(b);
    end
    send_byte(crc8frc_pkg::NEWLINE);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (frame_out_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic byte_q_t rand_payload(input int len);
    byte_q_t q;
    repeat (len) begin
      q.push_back(($urandom_range(0, 9) == 0) ? crc8frc_pkg::NEWLINE : 8'($urandom));
    end
    return q;
  endfunction

  function automatic int rand_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 6);
    if (pick < 95) return $urandom_range(7, MAX_PAYLOAD - 1);
    return MAX_PAYLOAD;
  endfunction

  function automatic logic [7:0] rand_non_newline();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == crc8frc_pkg::NEWLINE) ? 8'hFF : b;
  endfunction

  task automatic test_empty_frame();
    byte_q_t none;
    send_frame(none, 1'b1, crc8frc_pkg::NEWLINE);
  endtask

  task automatic test_payload_extremes();
    byte_q_t pay;
    pay.push_back(8'h00);
    pay.push_back(8'hFF);
    pay.push_back(crc8frc_pkg::NEWLINE);
    send_frame(pay, 1'b1, crc8frc_pkg::NEWLINE);
  endtask

  task automatic test_crc_mismatch();
    byte_q_t pay;
    pay.push_back(8'h55);
    send_frame(pay, 1'b0, crc8frc_pkg::NEWLINE);
  endtask

  task automatic test_bad_size();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(crc8frc_pkg::NEWLINE);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_junk_line(1);
    send_byte(8'h5A);
    send_byte(8'(MAX_PAYLOAD + 2));
    send_byte(crc8frc_pkg::NEWLINE);
  endtask

  task automatic test_bad_terminator();
    byte_q_t none;
    send_frame(none, 1'b1, 8'hFF);
    send_junk_line(1);
  endtask

  task automatic test_pause_until_drained();
    send_frame(rand_payload(4), 1'b1, crc8frc_pkg::NEWLINE);
    wait_for_drain();
    send_frame(rand_payload(2), 1'b1, crc8frc_pkg::NEWLINE);
    wait_for_drain();
  endtask

  task automatic test_random_frames();
    int target;
    int pick;
    target = sent_items + RANDOM_ITEMS;
    send_frame(rand_payload(MAX_PAYLOAD), 1'b1, crc8frc_pkg::NEWLINE);
    while (sent_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(rand_payload(rand_len()), 1'b1, crc8frc_pkg::NEWLINE);
      end else if (pick < 75) begin
        send_frame(rand_payload(rand_len()), 1'b0, crc8frc_pkg::NEWLINE);
      end else if (pick < 82) begin
        send_byte(8'($urandom));
        send_byte(($urandom_range(0, 1) == 0) ? 8'h00 :
                  8'($urandom_range(MAX_PAYLOAD + 2, 255)));
        send_junk_line($urandom_range(0, 3));
      end else if (pick < 88) begin
        send_frame(rand_payload(rand_len()), 1'b1, rand_non_newline());
        send_junk_line($urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  // receiver stall pattern
  stall_style_e stall_style = NO_STALL;
  int           stall_left = 0;
  int           stall_tick = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 64);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      NO_STALL:       out_stall_i <= 1'b0;
      SPARSE_STALL:   out_stall_i <= ($urandom_range(0, 3) == 0);
      PERIODIC_STALL: out_stall_i <= ((stall_tick % 7) < 5);
      default:        out_stall_i <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic void check_field(input string fname, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_out_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual kind %0d data %h",
                 $time, kind_o, data_o);
        mismatch_count++;
      end else begin
        want = frame_out_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(kind_o));
        check_field("data", want.data, data_o);
        check_field("status", 8'(want.status), 8'(status_o));
        check_field("send_ack", 8'(want.ack), 8'(send_ack_o));
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_frame();
    test_payload_extremes();
    test_crc_mismatch();
    test_bad_size();
    test_bad_terminator();
    wait_for_drain();
    test_pause_until_drained();
    test_random_frames();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && frame_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
